// ===== src/clcg_pkg.sv =====
`default_nettype none

package clcg_pkg;

   localparam int unsigned SEED_W = 31;

   typedef enum logic {
      CMD_DRAW = 1'b0,
      CMD_LOAD = 1'b1
   } cmd_type;

   // multipliers and moduli of the two component congruences
   localparam logic [15:0]       MUL_FIRST    = 16'd40014;
   localparam logic [15:0]       MUL_SECOND   = 16'd40692;
   localparam logic [SEED_W-1:0] MOD_FIRST    = 31'd2147483563;
   localparam logic [SEED_W-1:0] MOD_SECOND   = 31'd2147483399;
   localparam logic [SEED_W-1:0] MOD_OUT      = 31'd2147483562;
   localparam logic [SEED_W:0]   MOD_OUT2     = 32'd4294967124;
   localparam logic [SEED_W-1:0] MAX_FIRST    = 31'd2147483562;
   localparam logic [SEED_W-1:0] MAX_SECOND   = 31'd2147483398;
   localparam logic [SEED_W-1:0] RESET_FIRST  = 31'd1234567890;
   localparam logic [SEED_W-1:0] RESET_SECOND = 31'd123456789;

   // 2^31 mod M for each modulus: 2^31 - M
   localparam logic [6:0] FOLD_FIRST  = 7'd85;
   localparam logic [7:0] FOLD_SECOND = 8'd249;

   typedef struct packed {
      cmd_type           cmd;
      logic [SEED_W-1:0] seed_first;
      logic [SEED_W-1:0] seed_second;
   } req_type;

   typedef struct packed {
      logic [SEED_W-1:0] value;
      logic              seed_ok;
      logic [SEED_W-1:0] state_first;
      logic [SEED_W-1:0] state_second;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/clcg_req_if.sv =====
`default_nettype none

interface clcg_req_if import clcg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   cmd_type               cmd;
   logic [SEED_W-1:0]     seed_first;
   logic [SEED_W-1:0]     seed_second;

   modport source (output valid, output cmd, output seed_first, output seed_second,
                   input ready);
   modport sink   (input valid, input cmd, input seed_first, input seed_second,
                   output ready);
endinterface

`default_nettype wire

// ===== src/clcg_rsp_if.sv =====
`default_nettype none

interface clcg_rsp_if import clcg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [SEED_W-1:0]     value;
   logic                  seed_ok;
   logic [SEED_W-1:0]     state_first;
   logic [SEED_W-1:0]     state_second;

   modport source (output valid, output value, output seed_ok, output state_first,
                   output state_second, input ready);
   modport sink   (input valid, input value, input seed_ok, input state_first,
                   input state_second, output ready);
endinterface

`default_nettype wire

// ===== src/combined_lcg_two_stream_generator_core.sv =====
`default_nettype none

// Combined two-seed multiplicative congruential generator. A draw item
// advances both seeds and returns (first - second) mod 2147483562; a load item
// replaces both seeds when each is in range and otherwise reports seed_ok = 0
// with the seeds untouched. Every result carries the seeds after its item.
// Throughput is one item per clock unless rsp_chan.ready stalls; an accepted
// item waits in the input register and is stepped into the result register.
// The rate is set by the seed update loop, a 31x16 constant multiply, a
// constant fold and one compare-subtract per seed, combinational between them.
module combined_lcg_two_stream_generator_core import clcg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   clcg_req_if.sink   req_chan,
   clcg_rsp_if.source rsp_chan
);

   logic              in_valid_ff;
   logic              in_valid_in;
   req_type           in_ff;
   req_type           in_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   rsp_type           out_ff;
   rsp_type           out_in;
   logic [SEED_W-1:0] first_ff;
   logic [SEED_W-1:0] first_in;
   logic [SEED_W-1:0] second_ff;
   logic [SEED_W-1:0] second_in;
   rsp_type           step_rsp;
   logic              move;
   logic              req_take;
   logic              rsp_take;

   clcg_step u_step (
      .first_seed  (first_ff),
      .second_seed (second_ff),
      .req         (in_ff),
      .rsp         (step_rsp)
   );

   assign move           = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || move;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_take       = out_valid_ff && rsp_chan.ready;

   always_comb begin
      in_in        = in_ff;
      in_valid_in  = in_valid_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      if (req_take) begin
         in_in.cmd         = req_chan.cmd;
         in_in.seed_first  = req_chan.seed_first;
         in_in.seed_second = req_chan.seed_second;
         in_valid_in       = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
      if (move) begin
         out_in       = step_rsp;
         out_valid_in = 1'b1;
         first_in     = step_rsp.state_first;
         second_in    = step_rsp.state_second;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         first_ff     <= RESET_FIRST;
         second_ff    <= RESET_SECOND;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
      end
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.value        = out_ff.value;
   assign rsp_chan.seed_ok      = out_ff.seed_ok;
   assign rsp_chan.state_first  = out_ff.state_first;
   assign rsp_chan.state_second = out_ff.state_second;

`ifndef SYNTHESIS
   a_first_range : assert property (@(posedge clock) disable iff (reset)
      (first_ff != '0) && (first_ff <= MAX_FIRST))
      else $error("first seed out of range");

   a_second_range : assert property (@(posedge clock) disable iff (reset)
      (second_ff != '0) && (second_ff <= MAX_SECOND))
      else $error("second seed out of range");

   a_rsp_tracks_state : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.state_first == first_ff) && (out_ff.state_second == second_ff))
      else $error("result seeds differ from held seeds");

   a_reject_holds : assert property (@(posedge clock) disable iff (reset)
      (move && !step_rsp.seed_ok) |=> $stable(first_ff) && $stable(second_ff))
      else $error("rejected load changed the seeds");

   a_value_range : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.value < MOD_OUT))
      else $error("value out of range");
`endif

endmodule

`default_nettype wire

// ===== src/clcg_step.sv =====
`default_nettype none

module clcg_step import clcg_pkg::*; (
   input  logic [SEED_W-1:0] first_seed,
   input  logic [SEED_W-1:0] second_seed,
   input  req_type           req,
   output rsp_type           rsp
);

   logic [46:0]       prod_a;
   logic [46:0]       prod_b;
   logic [22:0]       fold_a;
   logic [23:0]       fold_b;
   logic [SEED_W:0]   sum_a;
   logic [SEED_W:0]   sum_b;
   logic [SEED_W-1:0] next_a;
   logic [SEED_W-1:0] next_b;
   logic [SEED_W+1:0] diff;
   logic [SEED_W-1:0] draw_value;
   logic              load_ok;

   // x*m = hi*2^31 + lo, and 2^31 == fold (mod M), so one fold and one subtract
   assign prod_a = {16'b0, first_seed} * {31'b0, MUL_FIRST};
   assign prod_b = {16'b0, second_seed} * {31'b0, MUL_SECOND};
   assign fold_a = {7'b0, prod_a[46:31]} * {16'b0, FOLD_FIRST};
   assign fold_b = {8'b0, prod_b[46:31]} * {16'b0, FOLD_SECOND};
   assign sum_a  = {1'b0, prod_a[30:0]} + {9'b0, fold_a};
   assign sum_b  = {1'b0, prod_b[30:0]} + {8'b0, fold_b};

   always_comb begin
      if (sum_a >= {1'b0, MOD_FIRST}) begin
         next_a = SEED_W'(sum_a - {1'b0, MOD_FIRST});
      end else begin
         next_a = sum_a[SEED_W-1:0];
      end
      if (sum_b >= {1'b0, MOD_SECOND}) begin
         next_b = SEED_W'(sum_b - {1'b0, MOD_SECOND});
      end else begin
         next_b = sum_b[SEED_W-1:0];
      end
   end

   assign diff = {2'b0, next_a} + {2'b0, MOD_OUT} - {2'b0, next_b};

   always_comb begin
      priority if (diff >= {1'b0, MOD_OUT2}) begin
         draw_value = SEED_W'(diff - {1'b0, MOD_OUT2});
      end else if (diff >= {2'b0, MOD_OUT}) begin
         draw_value = SEED_W'(diff - {2'b0, MOD_OUT});
      end else begin
         draw_value = diff[SEED_W-1:0];
      end
   end

   assign load_ok = (req.seed_first != '0) && (req.seed_first <= MAX_FIRST) &&
                    (req.seed_second != '0) && (req.seed_second <= MAX_SECOND);

   always_comb begin
      unique case (req.cmd)
         CMD_DRAW: begin
            rsp.value        = draw_value;
            rsp.seed_ok      = 1'b1;
            rsp.state_first  = next_a;
            rsp.state_second = next_b;
         end
         CMD_LOAD: begin
            rsp.value        = '0;
            rsp.seed_ok      = load_ok;
            rsp.state_first  = load_ok ? req.seed_first : first_seed;
            rsp.state_second = load_ok ? req.seed_second : second_seed;
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

endmodule

`default_nettype wire
